[rtl/fbcq_pkg.sv]
package fbcq_pkg;

    localparam int COUNT_W    = 16;
    localparam int THRESH_W   = 7;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;
    localparam int NUM_KEYS   = 4;

    localparam logic [COUNT_W-1:0]  COUNT_MAX          = '1;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET    = 7'd3;
    localparam logic [COUNT_W-1:0]  STUCK_LIMIT_RESET  = 16'd1000;

    typedef enum logic [1:0] {
        MOTION_STAND = 2'd0,
        MOTION_WALK  = 2'd1,
        MOTION_OTHER = 2'd2,
        MOTION_SPARE = 2'd3
    } motion_t;

    typedef enum logic [2:0] {
        PHASE_INITIAL = 3'd0,
        PHASE_READY   = 3'd1,
        PHASE_SET     = 3'd2,
        PHASE_PLAYING = 3'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_DEFECT  = 2'd0,
        CFG_RIGHT_DEFECT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_STUCK_LIMIT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              contact;
        logic [COUNT_W-1:0] duration;
        logic [TIME_W-1:0]  last;
    } foot_result_t;

endpackage

[rtl/fbcq_key.sv]
module fbcq_key (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            enable,
    input  logic                            pressed,
    input  logic [fbcq_pkg::COUNT_W-1:0]    stuck_limit,
    output logic                            trusted
);

    logic [fbcq_pkg::COUNT_W-1:0] count_reg;
    logic [fbcq_pkg::COUNT_W-1:0] count_next;

    always_comb begin
        if (!pressed) begin
            count_next = '0;
        end else if (count_reg == fbcq_pkg::COUNT_MAX) begin
            count_next = count_reg;
        end else begin
            count_next = count_reg + 1'b1;
        end
        trusted = pressed && (count_next < stuck_limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (enable) begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/fbcq_foot.sv]
module fbcq_foot #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic                             contact,
    input  logic                             gate,
    input  logic [fbcq_pkg::THRESH_W-1:0]    threshold,
    input  logic [fbcq_pkg::TIME_W-1:0]      now,
    output fbcq_pkg::foot_result_t           result
);

    localparam int SUM_W = $clog2(WINDOW_LEN + 1);
    localparam int THR_W = fbcq_pkg::THRESH_W;

    logic [WINDOW_LEN-1:0]             win_reg;
    logic [WINDOW_LEN-1:0]             win_next;
    logic [SUM_W-1:0]                  sum_reg;
    logic [SUM_W-1:0]                  sum_next;
    logic [fbcq_pkg::COUNT_W-1:0]      run_reg;
    logic [fbcq_pkg::COUNT_W-1:0]      run_next;
    logic [fbcq_pkg::TIME_W-1:0]       held_reg;
    logic [fbcq_pkg::TIME_W-1:0]       held_next;
    logic                              report;

    // newest bit in at the bottom, oldest drops out at the top
    always_comb begin
        win_next[0] = contact;
        for (int i = 1; i < WINDOW_LEN; i++) begin
            win_next[i] = win_reg[i-1];
        end
        sum_next = sum_reg - SUM_W'(win_reg[WINDOW_LEN-1]) + SUM_W'(contact);
        if (!contact) begin
            run_next = '0;
        end else if (run_reg == fbcq_pkg::COUNT_MAX) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + 1'b1;
        end
        report    = gate && (THR_W'(sum_next) > threshold);
        held_next = (report && contact) ? now : held_reg;
        result.contact  = report;
        result.duration = report ? run_next : '0;
        result.last     = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= '0;
            sum_reg  <= '0;
            run_reg  <= '0;
            held_reg <= '0;
        end else if (accept) begin
            win_reg  <= win_next;
            sum_reg  <= sum_next;
            run_reg  <= run_next;
            held_reg <= held_next;
        end
    end

    a_sum_matches_window: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(win_reg) == int'(sum_reg))
        else $error("window sum out of step with window bits");

    a_held_only_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(held_reg))
        else $error("held timestamp changed without a request");

    a_run_cleared_without_contact: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !contact |=> run_reg == '0)
        else $error("run length not cleared on a frame without contact");

endmodule

[rtl/foot_bumper_contact_qualifier.sv]
// Foot bumper contact qualifier.
// Input stream s_*: one request per sensor frame carrying the four bumper key
// levels, motion code, game phase, upright flag and frame timestamp.
// Output stream m_*: one result per request with qualified contact, contact
// duration and held last-contact timestamp for each foot.
// Config port: cfg_wr_en/cfg_index/cfg_wr_data; the user must write it only
// while idle, as the block itself does not enforce this; index 0 left defect,
// 1 right defect, 2 window threshold, 3 stuck limit. The result is registered:
// a request accepted at one edge has its result on m_tdata with m_tvalid high
// after that edge. One request per cycle is taken while s_tready is high; the
// key counters and window sums feed the result register combinationally.
// s_tready is high while the result register is empty or being taken, so a
// stalled receiver holds the result and back-pressures the input with no
// loss. Reset (aresetn low, synchronous) clears all counters, windows, held
// timestamps and the result valid, and loads the register defaults
// (threshold 3, stuck limit 1000, no defective foot).
module foot_bumper_contact_qualifier #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // left_outer_pressed, left_inner_pressed, right_inner_pressed,
    // right_outer_pressed, motion_code, game_phase, upright, frame_time
    input  logic [fbcq_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // contact_left, contact_right, duration_left, duration_right,
    // last_contact_left, last_contact_right
    output logic [fbcq_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [fbcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbcq_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    logic                              left_defect_reg;
    logic                              right_defect_reg;
    logic [fbcq_pkg::THRESH_W-1:0]     threshold_reg;
    logic [fbcq_pkg::COUNT_W-1:0]      stuck_limit_reg;

    logic                              accept;
    logic [fbcq_pkg::NUM_KEYS-1:0]     key_enable;
    logic [fbcq_pkg::NUM_KEYS-1:0]     key_trusted;
    logic                              contact_left;
    logic                              contact_right;
    logic                              gate;
    fbcq_pkg::motion_t                 motion;
    fbcq_pkg::phase_t                  phase;
    logic                              upright;
    logic [fbcq_pkg::TIME_W-1:0]       now;
    fbcq_pkg::foot_result_t            left_result;
    fbcq_pkg::foot_result_t            right_result;

    logic                              m_tvalid_reg;
    logic [fbcq_pkg::OUT_DATA_W-1:0]   m_tdata_reg;
    logic [fbcq_pkg::OUT_DATA_W-1:0]   m_tdata_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_defect_reg  <= 1'b0;
            right_defect_reg <= 1'b0;
            threshold_reg    <= fbcq_pkg::THRESHOLD_RESET;
            stuck_limit_reg  <= fbcq_pkg::STUCK_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (fbcq_pkg::cfg_index_t'(cfg_index))
                fbcq_pkg::CFG_LEFT_DEFECT:  left_defect_reg  <= cfg_wr_data[0];
                fbcq_pkg::CFG_RIGHT_DEFECT: right_defect_reg <= cfg_wr_data[0];
                fbcq_pkg::CFG_THRESHOLD:    threshold_reg    <= cfg_wr_data[fbcq_pkg::THRESH_W-1:0];
                fbcq_pkg::CFG_STUCK_LIMIT:  stuck_limit_reg  <= cfg_wr_data[fbcq_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign motion  = fbcq_pkg::motion_t'(s_tdata[5:4]);
    assign phase   = fbcq_pkg::phase_t'(s_tdata[8:6]);
    assign upright = s_tdata[9];
    assign now     = s_tdata[41:10];

    // a defective foot freezes its key counters
    assign key_enable = {{2{accept && !right_defect_reg}}, {2{accept && !left_defect_reg}}};

    for (genvar k = 0; k < fbcq_pkg::NUM_KEYS; k++) begin : g_key
        fbcq_key u_key (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .enable      (key_enable[k]),
            .pressed     (s_tdata[k]),
            .stuck_limit (stuck_limit_reg),
            .trusted     (key_trusted[k])
        );
    end

    assign contact_left  = !left_defect_reg && (key_trusted[0] || key_trusted[1]);
    assign contact_right = !right_defect_reg && (key_trusted[2] || key_trusted[3]);

    assign gate = (motion == fbcq_pkg::MOTION_STAND || motion == fbcq_pkg::MOTION_WALK)
               && (phase == fbcq_pkg::PHASE_READY || phase == fbcq_pkg::PHASE_SET
                   || phase == fbcq_pkg::PHASE_PLAYING)
               && upright;

    fbcq_foot #(.WINDOW_LEN(WINDOW_LEN)) u_foot_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .contact   (contact_left),
        .gate      (gate),
        .threshold (threshold_reg),
        .now       (now),
        .result    (left_result)
    );

    fbcq_foot #(.WINDOW_LEN(WINDOW_LEN)) u_foot_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .contact   (contact_right),
        .gate      (gate),
        .threshold (threshold_reg),
        .now       (now),
        .result    (right_result)
    );

    assign m_tdata_next = {6'd0,
                           right_result.last, left_result.last,
                           right_result.duration, left_result.duration,
                           right_result.contact, left_result.contact};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_left_duration_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[17:2] == '0)
        else $error("left duration shown without reported contact");

    a_right_duration_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[33:18] == '0)
        else $error("right duration shown without reported contact");

    a_no_report_when_gate_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !gate |=> m_tdata[1:0] == '0)
        else $error("contact reported with gate closed");

endmodule

[verif/foot_bumper_contact_qualifier_chk.sv]
module foot_bumper_contact_qualifier_chk #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // left_outer_pressed, left_inner_pressed, right_inner_pressed,
    // right_outer_pressed, motion_code, game_phase, upright, frame_time
    input  logic [fbcq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // contact_left, contact_right, duration_left, duration_right,
    // last_contact_left, last_contact_right
    input  logic [fbcq_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [fbcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbcq_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output int                                 mismatches,
    output int                                 outstanding
);

    logic                          left_defect;
    logic                          right_defect;
    logic [fbcq_pkg::THRESH_W-1:0] threshold;
    logic [fbcq_pkg::COUNT_W-1:0]  stuck_limit;

    logic [fbcq_pkg::COUNT_W-1:0]  press_count [fbcq_pkg::NUM_KEYS];
    logic                          win_left [WINDOW_LEN];
    logic                          win_right [WINDOW_LEN];
    int unsigned                   win_pos;
    logic [fbcq_pkg::THRESH_W-1:0] sum_left;
    logic [fbcq_pkg::THRESH_W-1:0] sum_right;
    logic [fbcq_pkg::COUNT_W-1:0]  run_left;
    logic [fbcq_pkg::COUNT_W-1:0]  run_right;
    logic [fbcq_pkg::TIME_W-1:0]   held_left;
    logic [fbcq_pkg::TIME_W-1:0]   held_right;

    logic [fbcq_pkg::OUT_DATA_W-1:0] expected_contacts [$];
    int                              errors;

    task automatic qualify_frame(input logic [fbcq_pkg::IN_DATA_W-1:0] d,
                                 output logic [fbcq_pkg::OUT_DATA_W-1:0] r);
        logic [fbcq_pkg::NUM_KEYS-1:0] keys;
        logic [fbcq_pkg::NUM_KEYS-1:0] trusted;
        fbcq_pkg::motion_t             motion;
        fbcq_pkg::phase_t              phase;
        logic                          upright;
        logic [fbcq_pkg::TIME_W-1:0]   stamp;
        logic                          cl;
        logic                          cr;
        logic                          gate;
        logic                          rep_l;
        logic                          rep_r;

        keys    = d[3:0];
        motion  = fbcq_pkg::motion_t'(d[5:4]);
        phase   = fbcq_pkg::phase_t'(d[8:6]);
        upright = d[9];
        stamp   = d[41:10];
        trusted = '0;

        // a defective foot keeps its press counts frozen
        for (int k = 0; k < fbcq_pkg::NUM_KEYS; k++) begin
            if (!((k < 2) ? left_defect : right_defect)) begin
                if (keys[k]) begin
                    if (press_count[k] != fbcq_pkg::COUNT_MAX)
                        press_count[k] = press_count[k] + 1'b1;
                end else begin
                    press_count[k] = '0;
                end
                trusted[k] = keys[k] && (press_count[k] < stuck_limit);
            end
        end
        cl = trusted[0] | trusted[1];
        cr = trusted[2] | trusted[3];

        sum_left  = sum_left - fbcq_pkg::THRESH_W'(win_left[win_pos])
                  + fbcq_pkg::THRESH_W'(cl);
        sum_right = sum_right - fbcq_pkg::THRESH_W'(win_right[win_pos])
                  + fbcq_pkg::THRESH_W'(cr);
        win_left[win_pos]  = cl;
        win_right[win_pos] = cr;
        win_pos = (win_pos + 1) % WINDOW_LEN;

        if (!cl)
            run_left = '0;
        else if (run_left != fbcq_pkg::COUNT_MAX)
            run_left = run_left + 1'b1;
        if (!cr)
            run_right = '0;
        else if (run_right != fbcq_pkg::COUNT_MAX)
            run_right = run_right + 1'b1;

        gate = (motion == fbcq_pkg::MOTION_STAND || motion == fbcq_pkg::MOTION_WALK)
            && (phase == fbcq_pkg::PHASE_READY || phase == fbcq_pkg::PHASE_SET
                || phase == fbcq_pkg::PHASE_PLAYING)
            && upright;
        rep_l = gate && (sum_left > threshold);
        rep_r = gate && (sum_right > threshold);
        if (rep_l && cl)
            held_left = stamp;
        if (rep_r && cr)
            held_right = stamp;

        r        = '0;
        r[0]     = rep_l;
        r[1]     = rep_r;
        r[17:2]  = rep_l ? run_left : '0;
        r[33:18] = rep_r ? run_right : '0;
        r[65:34] = held_left;
        r[97:66] = held_right;
    endtask

    always @(posedge aclk) begin : track
        logic [fbcq_pkg::OUT_DATA_W-1:0] want;
        logic [31:0]                     want_f;
        logic [31:0]                     got_f;
        string                           fname;

        if (!aresetn) begin
            left_defect  = 1'b0;
            right_defect = 1'b0;
            threshold    = fbcq_pkg::THRESHOLD_RESET;
            stuck_limit  = fbcq_pkg::STUCK_LIMIT_RESET;
            for (int k = 0; k < fbcq_pkg::NUM_KEYS; k++)
                press_count[k] = '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_left[i]  = 1'b0;
                win_right[i] = 1'b0;
            end
            win_pos    = 0;
            sum_left   = '0;
            sum_right  = '0;
            run_left   = '0;
            run_right  = '0;
            held_left  = '0;
            held_right = '0;
            expected_contacts.delete();
            errors = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    fbcq_pkg::CFG_LEFT_DEFECT:  left_defect  = cfg_wr_data[0];
                    fbcq_pkg::CFG_RIGHT_DEFECT: right_defect = cfg_wr_data[0];
                    fbcq_pkg::CFG_THRESHOLD:
                        threshold = cfg_wr_data[fbcq_pkg::THRESH_W-1:0];
                    fbcq_pkg::CFG_STUCK_LIMIT:
                        stuck_limit = cfg_wr_data[fbcq_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                qualify_frame(s_tdata, want);
                expected_contacts.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_contacts.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %0h", m_tdata);
                end else begin
                    want = expected_contacts.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        case (f)
                            0: begin
                                fname = "contact_left";
                                want_f = 32'(want[0]);
                                got_f  = 32'(m_tdata[0]);
                            end
                            1: begin
                                fname = "contact_right";
                                want_f = 32'(want[1]);
                                got_f  = 32'(m_tdata[1]);
                            end
                            2: begin
                                fname = "duration_left";
                                want_f = 32'(want[17:2]);
                                got_f  = 32'(m_tdata[17:2]);
                            end
                            3: begin
                                fname = "duration_right";
                                want_f = 32'(want[33:18]);
                                got_f  = 32'(m_tdata[33:18]);
                            end
                            4: begin
                                fname = "last_contact_left";
                                want_f = want[65:34];
                                got_f  = m_tdata[65:34];
                            end
                            default: begin
                                fname = "last_contact_right";
                                want_f = want[97:66];
                                got_f  = m_tdata[97:66];
                            end
                        endcase
                        if (got_f !== want_f) begin
                            errors++;
                            if (errors <= 10)
                                $display("%s mismatch: expected %0h, got %0h",
                                         fname, want_f, got_f);
                        end
                    end
                end
            end
        end
        outstanding <= expected_contacts.size();
        mismatches  <= errors;
    end

endmodule

[verif/foot_bumper_contact_qualifier_tb.sv]
module foot_bumper_contact_qualifier_tb;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [fbcq_pkg::IN_DATA_W-1:0]  s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [fbcq_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_wr_en   = 1'b0;
    logic [fbcq_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [fbcq_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    int mismatches;
    int outstanding;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs   = 0;
    int hold_done   = 0;
    int hold_left   = 0;

    logic [3:0] key_pattern = '0;

    foot_bumper_contact_qualifier DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    foot_bumper_contact_qualifier_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_done) begin
            m_tready  <= 1'b0;
            hold_done <= hold_reqs;
            hold_left <= 60;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [fbcq_pkg::IN_DATA_W-1:0] pack_frame(
        logic [3:0] keys,
        logic [1:0] motion,
        logic [2:0] phase,
        logic up,
        logic [fbcq_pkg::TIME_W-1:0] stamp);
        return {6'b0, stamp, up, phase, motion, keys};
    endfunction

    task automatic send(input logic [fbcq_pkg::IN_DATA_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= fbcq_pkg::IN_DATA_W'({$urandom, $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic set_config(logic ld, logic rd, logic [fbcq_pkg::THRESH_W-1:0] thr,
                              logic [fbcq_pkg::COUNT_W-1:0] lim);
        drain();
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= fbcq_pkg::CFG_LEFT_DEFECT;
        cfg_wr_data <= {15'($urandom), ld};
        @(posedge aclk);
        cfg_index   <= fbcq_pkg::CFG_RIGHT_DEFECT;
        cfg_wr_data <= {15'($urandom), rd};
        @(posedge aclk);
        cfg_index   <= fbcq_pkg::CFG_THRESHOLD;
        cfg_wr_data <= {9'($urandom), thr};
        @(posedge aclk);
        cfg_index   <= fbcq_pkg::CFG_STUCK_LIMIT;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [fbcq_pkg::IN_DATA_W-1:0] frame;
        logic [1:0]                     motion;
        logic [2:0]                     phase;
        logic                           up;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, gate conditions, timestamp extremes
        send(pack_frame(4'b0000, fbcq_pkg::MOTION_STAND, fbcq_pkg::PHASE_INITIAL, 1'b0, '0));
        for (int i = 0; i < 5; i++)
            send(pack_frame(4'b1111, fbcq_pkg::MOTION_STAND, fbcq_pkg::PHASE_PLAYING,
                            1'b1, 100 + i));
        // reported without current contact
        send(pack_frame(4'b0000, fbcq_pkg::MOTION_WALK, fbcq_pkg::PHASE_READY, 1'b1, '1));
        send(pack_frame(4'b0101, fbcq_pkg::MOTION_OTHER, fbcq_pkg::PHASE_SET, 1'b1, '1));
        send(pack_frame(4'b1010, fbcq_pkg::MOTION_SPARE, fbcq_pkg::PHASE_PLAYING, 1'b1, '1));
        for (int p = 0; p < 8; p++)
            send(pack_frame(4'b0011, fbcq_pkg::MOTION_STAND, 3'(p), 1'b1, 200 + p));
        send(pack_frame(4'b1111, fbcq_pkg::MOTION_WALK, fbcq_pkg::PHASE_PLAYING, 1'b0, 300));
        send(pack_frame(4'b1111, fbcq_pkg::MOTION_WALK, fbcq_pkg::PHASE_PLAYING, 1'b1, '1));

        // random phases across settings and idle patterns
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_config(1'b0, 1'b0, 7'd3, 16'd1000);
                1: set_config(1'b1, 1'b0, 7'd0, 16'd0);
                2: set_config(1'b0, 1'b1, 7'd64, 16'hFFFF);
                3: set_config(1'b1, 1'b1, 7'd2, 16'd8);
                4: set_config(1'b0, 1'b0, 7'd16, 16'd4);
                5: set_config(1'b0, 1'b0, 7'd15, 16'hFFFF);
                6: set_config(1'b0, 1'b1, 7'd1, 16'd1);
                7: set_config(1'b0, 1'b0, 7'($urandom_range(8)),
                              16'($urandom_range(40, 2)));
                default: set_config(1'b1, 1'b0, 7'($urandom_range(8)),
                                    16'($urandom_range(300, 1)));
            endcase
            if (p < 3) begin
                tx_idle_pct = 28;
                rx_idle_pct = 81;
            end else if (p < 6) begin
                tx_idle_pct = 81;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < 72; n++) begin
                if ((p == 1 && n == 10) || (p == 7 && n == 30))
                    hold_reqs <= hold_reqs + 1;
                if (p == 4 && n == 36)
                    drain();
                if ($urandom_range(99) < 12)
                    key_pattern = 4'($urandom);
                if ($urandom_range(99) < 15) begin
                    frame = {6'b0, 42'({$urandom, $urandom})};
                end else begin
                    motion = ($urandom_range(99) < 80) ? 2'($urandom_range(1))
                                                       : 2'($urandom_range(3, 2));
                    if ($urandom_range(99) < 80)
                        phase = 3'($urandom_range(3, 1));
                    else
                        phase = ($urandom_range(1) == 0) ? 3'(fbcq_pkg::PHASE_INITIAL)
                                                         : 3'($urandom_range(7, 4));
                    up = ($urandom_range(99) < 90);
                    frame = pack_frame(key_pattern, motion, phase, up, $urandom);
                end
                send(frame);
            end
        end

        drain();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("foot_bumper_contact_qualifier_tb: PASS");
        else
            $display("foot_bumper_contact_qualifier_tb: FAIL");
        $finish;
    end

    initial begin
        #500000;
        $display("foot_bumper_contact_qualifier_tb: FAIL");
        $finish;
    end

endmodule
